// File: hdl/hlc_pkg.sv
// Package for the homogeneous line clipper: outcode bits, edge and register codes,
// default widths, window reset values and the corner-code edge selection table.
// No dependencies; every other file of the clipper uses it.
package hlc_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT   = 4;
   localparam int DIV_BITS_PER_STAGE  = 4;

   localparam longint WINDOW_LEFT_PIXELS   = 200;
   localparam longint WINDOW_RIGHT_PIXELS  = 600;
   localparam longint WINDOW_BOTTOM_PIXELS = 100;
   localparam longint WINDOW_TOP_PIXELS    = 500;

   localparam logic [3:0] OC_LEFT   = 4'b1000;
   localparam logic [3:0] OC_RIGHT  = 4'b0100;
   localparam logic [3:0] OC_TOP    = 4'b0010;
   localparam logic [3:0] OC_BOTTOM = 4'b0001;
   localparam logic [3:0] OC_NONE   = 4'b0000;

   typedef enum logic [1:0] {
      EDGE_BOTTOM,
      EDGE_RIGHT,
      EDGE_TOP,
      EDGE_LEFT
   } edge_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_LEFT,
      CSR_WINDOW_RIGHT,
      CSR_WINDOW_BOTTOM,
      CSR_WINDOW_TOP
   } csr_index_type;

   typedef struct packed {
      logic       ok;
      edge_type   ei;
      edge_type   ej;
      logic [3:0] mask;
   } pick_type;

   function automatic pick_type edge_pick(input logic [3:0] code);
      pick_type p;
      p = '{ok: 1'b0, ei: EDGE_BOTTOM, ej: EDGE_BOTTOM, mask: OC_NONE};
      unique case (code) inside
         4'd1, 4'd14: begin
            p = '{ok: 1'b1, ei: EDGE_BOTTOM, ej: EDGE_LEFT, mask: OC_RIGHT};
         end
         4'd2, 4'd13: begin
            p = '{ok: 1'b1, ei: EDGE_BOTTOM, ej: EDGE_RIGHT, mask: OC_RIGHT};
         end
         4'd3, 4'd12: begin
            p = '{ok: 1'b1, ei: EDGE_RIGHT, ej: EDGE_LEFT, mask: OC_TOP};
         end
         4'd4, 4'd11: begin
            p = '{ok: 1'b1, ei: EDGE_RIGHT, ej: EDGE_TOP, mask: OC_TOP};
         end
         4'd6, 4'd9: begin
            p = '{ok: 1'b1, ei: EDGE_BOTTOM, ej: EDGE_TOP, mask: OC_RIGHT};
         end
         4'd7, 4'd8: begin
            p = '{ok: 1'b1, ei: EDGE_TOP, ej: EDGE_LEFT, mask: OC_LEFT};
         end
         default: begin
            p = '{ok: 1'b0, ei: EDGE_BOTTOM, ej: EDGE_BOTTOM, mask: OC_NONE};
         end
      endcase
      return p;
   endfunction

endpackage

// File: hdl/hlc_if.sv
// Valid/ready channel interfaces of the line clipper: segment requests and clip responses.
// Depends on hlc_pkg for the default coordinate width.
interface hlc_req_if #(parameter int COORD_WIDTH = hlc_pkg::COORD_WIDTH_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface hlc_rsp_if #(parameter int COORD_WIDTH = hlc_pkg::COORD_WIDTH_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic                          visible;
   logic signed [COORD_WIDTH-1:0] out_start_x;
   logic signed [COORD_WIDTH-1:0] out_start_y;
   logic signed [COORD_WIDTH-1:0] out_end_x;
   logic signed [COORD_WIDTH-1:0] out_end_y;

   modport source (output valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                   input ready);
   modport sink (input valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                 output ready);
endinterface

// File: hdl/homogeneous_line_clipper_unit.sv
// Top level of the homogeneous line clipper: window registers, corner-code pipeline and
// a pipelined restoring divider for both edge intersections.
// Depends on hlc_pkg and the channel interfaces in hlc_if.sv.
//
// Usage: a segment transaction on req_bus carries two endpoints in signed fixed point.
// After the corner-code stages and the divider stages, a response transaction on rsp_bus
// carries the visible flag and the clipped endpoints, or zeros when nothing of the
// segment lies in the window. The block takes one segment per cycle while rsp_bus
// does not stall; the depth is set by the divider, which resolves four quotient bits
// per stage, and two intersections run side by side.
// Responses leave in the order the segments arrived.
// The user writes the window through the csr port (left, right, bottom, top) only while
// no segment is in flight; the block does not enforce this. Reset is synchronous: it
// empties the pipeline and loads the window with 200.0, 600.0, 100.0 and 500.0 pixels.
// When the receiver holds rsp_bus.ready low with a response waiting, the whole pipeline
// holds and req_bus.ready drops in the same cycle; nothing is dropped or repeated.
module homogeneous_line_clipper_unit #(
   parameter int COORD_WIDTH = hlc_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = hlc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   hlc_req_if.sink                       req_bus,
   hlc_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  hlc_pkg::csr_index_type        csr_index,
   input  logic signed [COORD_WIDTH-1:0] csr_write_data
);
   import hlc_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int BPS   = DIV_BITS_PER_STAGE;
   localparam int UW    = 2 * CW + 2;
   localparam int NDIV  = (UW + BPS - 1) / BPS;
   localparam int PW    = NDIV * BPS;
   localparam int NSTG  = NDIV + 7;

   localparam logic signed [CW-1:0] RESET_LEFT   = CW'(WINDOW_LEFT_PIXELS << FRAC_BITS);
   localparam logic signed [CW-1:0] RESET_RIGHT  = CW'(WINDOW_RIGHT_PIXELS << FRAC_BITS);
   localparam logic signed [CW-1:0] RESET_BOTTOM = CW'(WINDOW_BOTTOM_PIXELS << FRAC_BITS);
   localparam logic signed [CW-1:0] RESET_TOP    = CW'(WINDOW_TOP_PIXELS << FRAC_BITS);

   localparam logic signed [PW+1:0] SAT_HI = (PW+2)'({(CW-1){1'b1}});
   localparam logic signed [PW+1:0] SAT_LO = ~SAT_HI;

   typedef logic signed [CW-1:0]   coord_type;
   typedef logic signed [CW:0]     diff_type;
   typedef logic signed [2*CW+1:0] prod_type;

   typedef struct packed {
      coord_type  x0, y0, x1, y1;
      logic [3:0] c0, c1;
      diff_type   x0l, x0r, x1l, x1r, y0b, y0t, y1b, y1t;
   } st1_type;

   typedef struct packed {
      coord_type      x0, y0, x1, y1;
      logic [3:0]     c0, c1;
      prod_type [3:0] pa;
      prod_type [3:0] pb;
   } st2_type;

   typedef struct packed {
      coord_type      x0, y0, x1, y1;
      logic           vis;
      logic [1:0]     en;
      edge_type [1:0] sel;
   } st3_type;

   typedef struct packed {
      logic      en;
      logic      horiz;
      coord_type kval;
      coord_type b0;
      diff_type  d;
      diff_type  bd;
      diff_type  ka;
   } pre_type;

   typedef struct packed {
      coord_type     x0, y0, x1, y1;
      logic          vis;
      pre_type [1:0] sl;
   } st4_type;

   typedef struct packed {
      logic          en;
      logic          horiz;
      coord_type     kval;
      coord_type     b0;
      logic          dneg;
      logic          dzero;
      logic [CW-1:0] dm;
      prod_type      prod;
   } mul_type;

   typedef struct packed {
      coord_type     x0, y0, x1, y1;
      logic          vis;
      mul_type [1:0] sl;
   } st5_type;

   typedef struct packed {
      logic          en;
      logic          horiz;
      coord_type     kval;
      coord_type     b0;
      logic          dzero;
      logic          qneg;
      logic [CW:0]   dvs;
      logic [CW:0]   rem;
      logic [PW-1:0] work;
   } div_slot_type;

   typedef struct packed {
      coord_type          x0, y0, x1, y1;
      logic               vis;
      div_slot_type [1:0] sl;
   } div_type;

   typedef struct packed {
      logic      visible;
      coord_type sx, sy, ex, ey;
   } out_type;

   function automatic div_slot_type div_step(input div_slot_type s_in);
      div_slot_type s;
      logic [CW+1:0] t;
      s = s_in;
      for (int b = 0; b < BPS; b++) begin
         t = {s.rem, s.work[PW-1]};
         s.work = {s.work[PW-2:0], 1'b0};
         if (t >= (CW+2)'(s.dvs)) begin
            t = t - (CW+2)'(s.dvs);
            s.work[0] = 1'b1;
         end
         s.rem = t[CW:0];
      end
      return s;
   endfunction

   coord_type win_left_ff, win_right_ff, win_bottom_ff, win_top_ff;
   logic [NSTG-1:0] vld_ff, vld_in;
   logic            advance;

   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;
   st3_type st3_ff, st3_in;
   st4_type st4_ff, st4_in;
   st5_type st5_ff, st5_in;
   div_type dv_ff [0:NDIV];
   div_type dv_head_in;
   div_type dv_in [1:NDIV];
   out_type out_ff, out_in;

   // Window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= RESET_LEFT;
         win_right_ff  <= RESET_RIGHT;
         win_bottom_ff <= RESET_BOTTOM;
         win_top_ff    <= RESET_TOP;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_LEFT:   win_left_ff   <= csr_write_data;
            CSR_WINDOW_RIGHT:  win_right_ff  <= csr_write_data;
            CSR_WINDOW_BOTTOM: win_bottom_ff <= csr_write_data;
            CSR_WINDOW_TOP:    win_top_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Pipeline control: every stage moves when the output slot is free or being taken.
   assign advance       = !vld_ff[NSTG-1] || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign vld_in        = {vld_ff[NSTG-2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: outcodes and corner differences.
   always_comb begin
      st1_in.x0 = req_bus.start_x;
      st1_in.y0 = req_bus.start_y;
      st1_in.x1 = req_bus.end_x;
      st1_in.y1 = req_bus.end_y;
      st1_in.c0 = OC_NONE;
      st1_in.c1 = OC_NONE;
      if (req_bus.start_x < win_left_ff) begin
         st1_in.c0 = OC_LEFT;
      end else if (req_bus.start_x >= win_right_ff) begin
         st1_in.c0 = OC_RIGHT;
      end
      if (req_bus.start_y < win_bottom_ff) begin
         st1_in.c0 = st1_in.c0 | OC_BOTTOM;
      end else if (req_bus.start_y >= win_top_ff) begin
         st1_in.c0 = st1_in.c0 | OC_TOP;
      end
      if (req_bus.end_x < win_left_ff) begin
         st1_in.c1 = OC_LEFT;
      end else if (req_bus.end_x >= win_right_ff) begin
         st1_in.c1 = OC_RIGHT;
      end
      if (req_bus.end_y < win_bottom_ff) begin
         st1_in.c1 = st1_in.c1 | OC_BOTTOM;
      end else if (req_bus.end_y >= win_top_ff) begin
         st1_in.c1 = st1_in.c1 | OC_TOP;
      end
      st1_in.x0l = (CW+1)'(req_bus.start_x) - (CW+1)'(win_left_ff);
      st1_in.x0r = (CW+1)'(req_bus.start_x) - (CW+1)'(win_right_ff);
      st1_in.x1l = (CW+1)'(req_bus.end_x) - (CW+1)'(win_left_ff);
      st1_in.x1r = (CW+1)'(req_bus.end_x) - (CW+1)'(win_right_ff);
      st1_in.y0b = (CW+1)'(req_bus.start_y) - (CW+1)'(win_bottom_ff);
      st1_in.y0t = (CW+1)'(req_bus.start_y) - (CW+1)'(win_top_ff);
      st1_in.y1b = (CW+1)'(req_bus.end_y) - (CW+1)'(win_bottom_ff);
      st1_in.y1t = (CW+1)'(req_bus.end_y) - (CW+1)'(win_top_ff);
   end

   // Stage 2: cross-product terms at the four corners.
   always_comb begin
      st2_in.x0    = st1_ff.x0;
      st2_in.y0    = st1_ff.y0;
      st2_in.x1    = st1_ff.x1;
      st2_in.y1    = st1_ff.y1;
      st2_in.c0    = st1_ff.c0;
      st2_in.c1    = st1_ff.c1;
      st2_in.pa[0] = (2*CW+2)'(st1_ff.x0l) * (2*CW+2)'(st1_ff.y1b);
      st2_in.pb[0] = (2*CW+2)'(st1_ff.x1l) * (2*CW+2)'(st1_ff.y0b);
      st2_in.pa[1] = (2*CW+2)'(st1_ff.x0r) * (2*CW+2)'(st1_ff.y1b);
      st2_in.pb[1] = (2*CW+2)'(st1_ff.x1r) * (2*CW+2)'(st1_ff.y0b);
      st2_in.pa[2] = (2*CW+2)'(st1_ff.x0r) * (2*CW+2)'(st1_ff.y1t);
      st2_in.pb[2] = (2*CW+2)'(st1_ff.x1r) * (2*CW+2)'(st1_ff.y0t);
      st2_in.pa[3] = (2*CW+2)'(st1_ff.x0l) * (2*CW+2)'(st1_ff.y1t);
      st2_in.pb[3] = (2*CW+2)'(st1_ff.x1l) * (2*CW+2)'(st1_ff.y0t);
   end

   // Stage 3: corner code, trivial accept or reject and edge selection.
   always_comb begin
      logic [3:0]            code;
      logic signed [2*CW+2:0] cv;
      pick_type              p;
      for (int k = 0; k < 4; k++) begin
         cv      = (2*CW+3)'(st2_ff.pa[k]) - (2*CW+3)'(st2_ff.pb[k]);
         code[k] = !cv[2*CW+2];
      end
      p = edge_pick(code);
      st3_in.x0  = st2_ff.x0;
      st3_in.y0  = st2_ff.y0;
      st3_in.x1  = st2_ff.x1;
      st3_in.y1  = st2_ff.y1;
      st3_in.vis = 1'b0;
      st3_in.en  = 2'b00;
      st3_in.sel = {p.ej, p.ei};
      if ((st2_ff.c0 | st2_ff.c1) == OC_NONE) begin
         st3_in.vis = 1'b1;
      end else if ((st2_ff.c0 & st2_ff.c1) != OC_NONE) begin
         st3_in.vis = 1'b0;
      end else if (p.ok) begin
         st3_in.vis = 1'b1;
         if (st2_ff.c0 != OC_NONE && st2_ff.c1 != OC_NONE) begin
            st3_in.en = 2'b11;
         end else if (st2_ff.c0 == OC_NONE) begin
            st3_in.en     = 2'b10;
            st3_in.sel[1] = ((st2_ff.c1 & p.mask) != OC_NONE) ? p.ei : p.ej;
         end else begin
            st3_in.en     = 2'b01;
            st3_in.sel[0] = ((st2_ff.c0 & p.mask) != OC_NONE) ? p.ei : p.ej;
         end
      end
   end

   // Stage 4: operands of each intersection.
   always_comb begin
      coord_type a0, a1, b1;
      st4_in.x0  = st3_ff.x0;
      st4_in.y0  = st3_ff.y0;
      st4_in.x1  = st3_ff.x1;
      st4_in.y1  = st3_ff.y1;
      st4_in.vis = st3_ff.vis;
      for (int s = 0; s < 2; s++) begin
         st4_in.sl[s].en    = st3_ff.en[s];
         st4_in.sl[s].horiz = (st3_ff.sel[s] == EDGE_BOTTOM) || (st3_ff.sel[s] == EDGE_TOP);
         case (st3_ff.sel[s])
            EDGE_BOTTOM: st4_in.sl[s].kval = win_bottom_ff;
            EDGE_RIGHT:  st4_in.sl[s].kval = win_right_ff;
            EDGE_TOP:    st4_in.sl[s].kval = win_top_ff;
            default:     st4_in.sl[s].kval = win_left_ff;
         endcase
         if (st4_in.sl[s].horiz) begin
            a0 = st3_ff.y0;
            a1 = st3_ff.y1;
            st4_in.sl[s].b0 = st3_ff.x0;
            b1 = st3_ff.x1;
         end else begin
            a0 = st3_ff.x0;
            a1 = st3_ff.x1;
            st4_in.sl[s].b0 = st3_ff.y0;
            b1 = st3_ff.y1;
         end
         st4_in.sl[s].d  = (CW+1)'(a1) - (CW+1)'(a0);
         st4_in.sl[s].bd = (CW+1)'(b1) - (CW+1)'(st4_in.sl[s].b0);
         st4_in.sl[s].ka = (CW+1)'(st4_in.sl[s].kval) - (CW+1)'(a0);
      end
   end

   // Stage 5: numerator products and denominator magnitude.
   always_comb begin
      diff_type dabs;
      st5_in.x0  = st4_ff.x0;
      st5_in.y0  = st4_ff.y0;
      st5_in.x1  = st4_ff.x1;
      st5_in.y1  = st4_ff.y1;
      st5_in.vis = st4_ff.vis;
      for (int s = 0; s < 2; s++) begin
         dabs = st4_ff.sl[s].d[CW] ? -st4_ff.sl[s].d : st4_ff.sl[s].d;
         st5_in.sl[s].en    = st4_ff.sl[s].en;
         st5_in.sl[s].horiz = st4_ff.sl[s].horiz;
         st5_in.sl[s].kval  = st4_ff.sl[s].kval;
         st5_in.sl[s].b0    = st4_ff.sl[s].b0;
         st5_in.sl[s].dneg  = st4_ff.sl[s].d[CW];
         st5_in.sl[s].dzero = (st4_ff.sl[s].d == '0);
         st5_in.sl[s].dm    = dabs[CW-1:0];
         st5_in.sl[s].prod  = (2*CW+2)'(st4_ff.sl[s].bd) * (2*CW+2)'(st4_ff.sl[s].ka);
      end
   end

   // Stage 6: rounding bias; a negative dividend is divided as its complement.
   always_comb begin
      prod_type                n;
      logic signed [2*CW+2:0] n2;
      logic [2*CW+2:0]        u;
      dv_head_in.x0  = st5_ff.x0;
      dv_head_in.y0  = st5_ff.y0;
      dv_head_in.x1  = st5_ff.x1;
      dv_head_in.y1  = st5_ff.y1;
      dv_head_in.vis = st5_ff.vis;
      for (int s = 0; s < 2; s++) begin
         n  = st5_ff.sl[s].dneg ? -st5_ff.sl[s].prod : st5_ff.sl[s].prod;
         n2 = {n, 1'b0} + (2*CW+3)'(st5_ff.sl[s].dm);
         u  = n2[2*CW+2] ? ~n2 : n2;
         dv_head_in.sl[s].en    = st5_ff.sl[s].en;
         dv_head_in.sl[s].horiz = st5_ff.sl[s].horiz;
         dv_head_in.sl[s].kval  = st5_ff.sl[s].kval;
         dv_head_in.sl[s].b0    = st5_ff.sl[s].b0;
         dv_head_in.sl[s].dzero = st5_ff.sl[s].dzero;
         dv_head_in.sl[s].qneg  = n2[2*CW+2];
         dv_head_in.sl[s].dvs   = {st5_ff.sl[s].dm, 1'b0};
         dv_head_in.sl[s].rem   = '0;
         dv_head_in.sl[s].work  = PW'(u[UW-1:0]);
      end
   end

   // Divider stages, four quotient bits each.
   always_comb begin
      for (int i = 1; i <= NDIV; i++) begin
         dv_in[i] = dv_ff[i-1];
         for (int s = 0; s < 2; s++) begin
            dv_in[i].sl[s] = div_step(dv_ff[i-1].sl[s]);
         end
      end
   end

   // Final stage: quotient sign, add base coordinate, saturate, assemble endpoints.
   always_comb begin
      logic [PW:0]          q;
      logic signed [PW+1:0] sum;
      coord_type            r [2];
      logic                 vis;
      vis = dv_ff[NDIV].vis;
      for (int s = 0; s < 2; s++) begin
         q   = {1'b0, dv_ff[NDIV].sl[s].work};
         q   = dv_ff[NDIV].sl[s].qneg ? ~q : q;
         sum = (PW+2)'(dv_ff[NDIV].sl[s].b0) + (PW+2)'(signed'(q));
         if (sum > SAT_HI) begin
            sum = SAT_HI;
         end else if (sum < SAT_LO) begin
            sum = SAT_LO;
         end
         r[s] = sum[CW-1:0];
         if (dv_ff[NDIV].sl[s].en && dv_ff[NDIV].sl[s].dzero) begin
            vis = 1'b0;
         end
      end
      out_in.visible = vis;
      out_in.sx = dv_ff[NDIV].x0;
      out_in.sy = dv_ff[NDIV].y0;
      out_in.ex = dv_ff[NDIV].x1;
      out_in.ey = dv_ff[NDIV].y1;
      if (dv_ff[NDIV].sl[0].en) begin
         out_in.sx = dv_ff[NDIV].sl[0].horiz ? r[0] : dv_ff[NDIV].sl[0].kval;
         out_in.sy = dv_ff[NDIV].sl[0].horiz ? dv_ff[NDIV].sl[0].kval : r[0];
      end
      if (dv_ff[NDIV].sl[1].en) begin
         out_in.ex = dv_ff[NDIV].sl[1].horiz ? r[1] : dv_ff[NDIV].sl[1].kval;
         out_in.ey = dv_ff[NDIV].sl[1].horiz ? dv_ff[NDIV].sl[1].kval : r[1];
      end
      if (!vis) begin
         out_in.sx = '0;
         out_in.sy = '0;
         out_in.ex = '0;
         out_in.ey = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         st4_ff <= st4_in;
         st5_ff <= st5_in;
         dv_ff[0] <= dv_head_in;
         for (int i = 1; i <= NDIV; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid       = vld_ff[NSTG-1];
   assign rsp_bus.visible     = out_ff.visible;
   assign rsp_bus.out_start_x = out_ff.sx;
   assign rsp_bus.out_start_y = out_ff.sy;
   assign rsp_bus.out_end_x   = out_ff.ex;
   assign rsp_bus.out_end_y   = out_ff.ey;

`ifndef NO_ASSERTIONS
   a_hidden_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.visible) |->
      (rsp_bus.out_start_x == '0 && rsp_bus.out_start_y == '0 &&
       rsp_bus.out_end_x == '0 && rsp_bus.out_end_y == '0))
      else $error("Hidden segment carries nonzero coordinates.");

   a_no_needless_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("Request channel stalled while the response slot is empty.");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("Response valid right after reset.");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for homogeneous_line_clipper_unit: drives segments with random
// bursts and response stalls, predicts each clip result in SystemVerilog and compares.
// Depends on hlc_pkg, hlc_if.sv and the clipper RTL.
`timescale 1ns / 100ps

module tb_top;
   import hlc_pkg::*;

   localparam int CW = 16;
   localparam int FB = 4;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic           visible;
      logic [CW-1:0]  sx;
      logic [CW-1:0]  sy;
      logic [CW-1:0]  ex;
      logic [CW-1:0]  ey;
   } clip_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_WINDOW_LEFT;
   logic signed [CW-1:0] csr_write_data = '0;

   hlc_req_if #(.COORD_WIDTH(CW)) req_bus ();
   hlc_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();

   homogeneous_line_clipper_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   longint win_left, win_right, win_bottom, win_top;
   clip_result_type expected_clips[$];
   int error_count = 0;
   int segment_count = 0;
   int visible_count = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int burst_left = 0;

   function automatic int unsigned outcode_of(longint x, longint y);
      int unsigned c = 0;
      if (x < win_left) c = OC_LEFT;
      else if (x >= win_right) c = OC_RIGHT;
      if (y < win_bottom) c |= OC_BOTTOM;
      else if (y >= win_top) c |= OC_TOP;
      return c;
   endfunction

   function automatic longint div_nearest(longint n, longint d);
      longint n2, d2, m, q;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      n2 = 2 * n + d;
      d2 = 2 * d;
      if (n2 >= 0) return n2 / d2;
      m = -n2;
      q = m / d2 + ((m % d2) != 0 ? 1 : 0);
      return -q;
   endfunction

   function automatic bit edge_cross(edge_type e, longint x0, longint y0, longint x1,
                                     longint y1, output longint px, output longint py);
      longint k;
      px = 0;
      py = 0;
      if (e == EDGE_BOTTOM || e == EDGE_TOP) begin
         k = (e == EDGE_BOTTOM) ? win_bottom : win_top;
         py = k;
         if (y1 == y0) return 1'b0;
         px = x0 + div_nearest((x1 - x0) * (k - y0), y1 - y0);
      end else begin
         k = (e == EDGE_RIGHT) ? win_right : win_left;
         px = k;
         if (x1 == x0) return 1'b0;
         py = y0 + div_nearest((y1 - y0) * (k - x0), x1 - x0);
      end
      return 1'b1;
   endfunction

   function automatic longint corner_cross(longint vx, longint vy, longint x0, longint y0,
                                           longint x1, longint y1);
      return (x0 - vx) * (y1 - vy) - (x1 - vx) * (y0 - vy);
   endfunction

   function automatic logic [CW-1:0] clamp_coord(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[CW-1:0];
   endfunction

   function automatic clip_result_type clip_segment(logic signed [CW-1:0] ax, ay, bx, by);
      longint x0, y0, x1, y1, sx, sy, ex, ey;
      int unsigned c0, c1, code;
      bit vis;
      logic ok;
      edge_type ei, ej, e;
      int unsigned mask;
      clip_result_type r;
      x0 = ax; y0 = ay; x1 = bx; y1 = by;
      sx = x0; sy = y0; ex = x1; ey = y1;
      c0 = outcode_of(x0, y0);
      c1 = outcode_of(x1, y1);
      vis = 1'b1;
      if ((c0 | c1) == 0) begin
         vis = 1'b1;
      end else if ((c0 & c1) != 0) begin
         vis = 1'b0;
      end else begin
         code = 0;
         if (corner_cross(win_left, win_bottom, x0, y0, x1, y1) >= 0) code |= 1;
         if (corner_cross(win_right, win_bottom, x0, y0, x1, y1) >= 0) code |= 2;
         if (corner_cross(win_right, win_top, x0, y0, x1, y1) >= 0) code |= 4;
         if (corner_cross(win_left, win_top, x0, y0, x1, y1) >= 0) code |= 8;
         ok = 1'b1;
         ei = EDGE_BOTTOM; ej = EDGE_BOTTOM; mask = 0;
         case (code)
            1, 14: begin ei = EDGE_BOTTOM; ej = EDGE_LEFT; mask = OC_RIGHT; end
            2, 13: begin ei = EDGE_BOTTOM; ej = EDGE_RIGHT; mask = OC_RIGHT; end
            3, 12: begin ei = EDGE_RIGHT; ej = EDGE_LEFT; mask = OC_TOP; end
            4, 11: begin ei = EDGE_RIGHT; ej = EDGE_TOP; mask = OC_TOP; end
            6, 9: begin ei = EDGE_BOTTOM; ej = EDGE_TOP; mask = OC_RIGHT; end
            7, 8: begin ei = EDGE_TOP; ej = EDGE_LEFT; mask = OC_LEFT; end
            default: ok = 1'b0;
         endcase
         if (!ok) begin
            vis = 1'b0;
         end else if (c0 != 0 && c1 != 0) begin
            vis = edge_cross(ei, x0, y0, x1, y1, sx, sy);
            if (vis) vis = edge_cross(ej, x0, y0, x1, y1, ex, ey);
         end else if (c0 == 0) begin
            e = ((c1 & mask) != 0) ? ei : ej;
            vis = edge_cross(e, x0, y0, x1, y1, ex, ey);
         end else begin
            e = ((c0 & mask) != 0) ? ei : ej;
            vis = edge_cross(e, x0, y0, x1, y1, sx, sy);
         end
      end
      r.visible = vis;
      r.sx = vis ? clamp_coord(sx) : '0;
      r.sy = vis ? clamp_coord(sy) : '0;
      r.ex = vis ? clamp_coord(ex) : '0;
      r.ey = vis ? clamp_coord(ey) : '0;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic send_segment(logic signed [CW-1:0] ax, ay, bx, by);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.start_x <= ax;
      req_bus.start_y <= ay;
      req_bus.end_x <= bx;
      req_bus.end_y <= by;
      expected_clips.push_back(clip_segment(ax, ay, bx, by));
      segment_count++;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_clips.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_window(csr_index_type idx, logic signed [CW-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      case (idx)
         CSR_WINDOW_LEFT: win_left = value;
         CSR_WINDOW_RIGHT: win_right = value;
         CSR_WINDOW_BOTTOM: win_bottom = value;
         default: win_top = value;
      endcase
   endtask

   task automatic set_window(logic signed [CW-1:0] l, r, b, t);
      wait_drained();
      write_window(CSR_WINDOW_LEFT, l);
      write_window(CSR_WINDOW_RIGHT, r);
      write_window(CSR_WINDOW_BOTTOM, b);
      write_window(CSR_WINDOW_TOP, t);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [CW-1:0] near_coord(longint a, longint b);
      int unsigned pick = $urandom_range(0, 9);
      longint v;
      if (pick == 0) return CW'($urandom);
      if (pick == 1) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      v = $urandom_range(0, 1) ? a : b;
      if (pick < 5) v = v + $signed($urandom_range(0, 8)) - 4;
      else v = a + longint'($urandom_range(0, 65535)) * (b - a + 400) / 65536 - 200;
      return clamp_coord(v);
   endfunction

   task automatic test_directed();
      send_segment(16'sd4000, 16'sd2000, 16'sd6000, 16'sd7000);
      send_segment(16'sd100, 16'sd100, 16'sd200, 16'sd200);
      send_segment(-16'sd32768, 16'sd4000, 16'sd32767, 16'sd4000);
      send_segment(16'sd5000, -16'sd32768, 16'sd5000, 16'sd32767);
      send_segment(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
      send_segment(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
      send_segment(16'sd4000, 16'sd4000, 16'sd20000, 16'sd4001);
      send_segment(16'sd4000, 16'sd4000, 16'sd4001, -16'sd20000);
      send_segment(16'sd0, 16'sd8000, 16'sd3200, 16'sd9000);
      send_segment(16'sd3200, 16'sd1600, 16'sd9599, 16'sd7999);
      send_segment(16'sd3199, 16'sd1600, 16'sd9600, 16'sd7999);
      send_segment(16'sd0, 16'sd0, 16'sd12000, 16'sd12001);
      send_segment(16'sd3000, 16'sd9000, 16'sd12000, 16'sd0);
      send_segment(16'sd6400, 16'sd0, 16'sd6401, 16'sd9000);
      send_segment(16'sd6400, 16'sd4800, 16'sd6400, 16'sd4800);
      send_segment(16'sd12000, 16'sd4000, 16'sd5000, 16'sd4003);
      send_segment(16'sd3000, 16'sd0, 16'sd3100, 16'sd9000);
      send_segment(16'sd1000, 16'sd1601, 16'sd9000, 16'sd1600);
      wait_drained();
   endtask

   task automatic test_random(int count);
      logic signed [CW-1:0] ax, ay, bx, by;
      repeat (count) begin
         ax = near_coord(win_left, win_right);
         ay = near_coord(win_bottom, win_top);
         bx = near_coord(win_left, win_right);
         by = near_coord(win_bottom, win_top);
         send_segment(ax, ay, bx, by);
      end
   endtask

   task automatic test_windows();
      set_window(16'sd0, 16'sd1600, 16'sd0, 16'sd1600);
      test_random(300);
      set_window(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      test_random(250);
      set_window(16'sd5000, 16'sd2000, 16'sd4000, 16'sd1000);
      test_random(150);
      set_window(16'sd3000, 16'sd3000, 16'sd2000, 16'sd2001);
      test_random(150);
      set_window(-16'sd20000, 16'sd30000, -16'sd8, 16'sd8);
      test_random(250);
      set_window(16'sd3200, 16'sd9600, 16'sd1600, 16'sd8000);
   endtask

   always @(posedge clock) begin
      clip_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_clips.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            want = expected_clips.pop_front();
            if (rsp_bus.visible !== want.visible)
               report_mismatch("visible", rsp_bus.visible, want.visible);
            if (rsp_bus.out_start_x !== want.sx)
               report_mismatch("out_start_x", rsp_bus.out_start_x, $signed(want.sx));
            if (rsp_bus.out_start_y !== want.sy)
               report_mismatch("out_start_y", rsp_bus.out_start_y, $signed(want.sy));
            if (rsp_bus.out_end_x !== want.ex)
               report_mismatch("out_end_x", rsp_bus.out_end_x, $signed(want.ex));
            if (rsp_bus.out_end_y !== want.ey)
               report_mismatch("out_end_y", rsp_bus.out_end_y, $signed(want.ey));
            if (want.visible) visible_count++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d transactions outstanding.",
                  expected_clips.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_bus.ready <= ($urandom_range(0, 2) == 0);
      endcase
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x = '0;
      req_bus.end_y = '0;
      win_left = WINDOW_LEFT_PIXELS << FB;
      win_right = WINDOW_RIGHT_PIXELS << FB;
      win_bottom = WINDOW_BOTTOM_PIXELS << FB;
      win_top = WINDOW_TOP_PIXELS << FB;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(500);
      wait_drained();
      test_windows();
      test_random(300);
      wait_drained();
      $display("Clipped %0d segments (%0d visible) over six window settings.",
               segment_count, visible_count);
      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
